FILE: rtl/core/kdaq_pkg.sv
// Shared types and constants for the key debounce / auto-repeat queue.
`timescale 1ns / 1ps
package kdaq_pkg;

  localparam int TIME_W  = 32;
  localparam int TICK_W  = 31;
  localparam int LEVEL_W = 3;
  localparam int CODE_W  = 2;
  localparam int CIDX_W  = 2;

  localparam logic [CIDX_W-1:0] REG_ENABLE       = 2'd0;
  localparam logic [CIDX_W-1:0] REG_FIRST_REPEAT = 2'd1;
  localparam logic [CIDX_W-1:0] REG_REPEAT       = 2'd2;
  localparam logic [CIDX_W-1:0] REG_RELEASE      = 2'd3;

  localparam logic [TICK_W-1:0] FIRST_REPEAT_RST = 31'd24000000;
  localparam logic [TICK_W-1:0] REPEAT_RST       = 31'd4800000;
  localparam logic [TICK_W-1:0] RELEASE_RST      = 31'd1440000;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic              push;
    logic [CODE_W-1:0] push_code;
    logic              rd;
    logic              pop;
  } fifo_ctrl_t;

  typedef struct packed {
    logic empty;
  } fifo_stat_t;

endpackage

FILE: rtl/core/key_debounce_autorepeat_queue.sv
// Top level: key debounce, auto-repeat and key-code queue with its sequencer.
`timescale 1ns / 1ps
// A scan item walks the keys one at a time through a single shared 32-bit
// adder/subtractor, with an evaluate state and an update state per key
// (S_EVAL, then S_UPD), before S_DONE; a scan while disabled goes from
// S_IDLE straight to S_DONE. A get item passes S_POP_RD and S_POP_TAKE, as
// the code FIFO has a registered read port. One item is in work at a time;
// the result sits in an output register, so the next item is taken while a
// result waits.
module key_debounce_autorepeat_queue #(
  parameter int NUM_KEYS   = 3,
  parameter int FIFO_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // key_levels[2:0], now[34:3], zero pad
  input  logic        in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // key_code[1:0], held_keys[4:2], none_held[5], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [kdaq_pkg::CIDX_W-1:0] cfg_index,
  input  logic [kdaq_pkg::TICK_W-1:0] cfg_data
);
  import kdaq_pkg::*;

  localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam logic [KEY_W-1:0] KEY_LAST = KEY_W'(NUM_KEYS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_UPD,
    S_POP_RD,
    S_POP_TAKE,
    S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic                enable_r, enable_nxt;
  logic [TICK_W-1:0]   first_r, first_nxt;
  logic [TICK_W-1:0]   repeat_r, repeat_nxt;
  logic [TICK_W-1:0]   release_r, release_nxt;
  logic [NUM_KEYS-1:0] held_r, held_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [LEVEL_W-1:0]  levels_r;
  logic [TIME_W-1:0]   now_r;
  logic [TIME_W-1:0]   base_r [NUM_KEYS];
  logic [TIME_W-1:0]   low_r  [NUM_KEYS];
  logic [TIME_W-1:0]   acc_r, acc_nxt;
  logic                reach_r, reach_nxt;
  logic [CODE_W-1:0]   code_r, code_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_data_r, out_data_nxt;
  logic                base_we, low_we;
  logic [TIME_W-1:0]   base_wdata;

  logic [NUM_KEYS-1:0] press_vec;
  logic                pressed, held_cur;
  logic [KEY_W:0]      key_plus1;
  logic [LEVEL_W-1:0]  held_out;

  alu_op_t             alu_op;
  logic [TIME_W-1:0]   alu_a, alu_b, alu_res;
  logic [TICK_W-1:0]   alu_thr;
  logic                alu_reached;

  fifo_ctrl_t          fctrl;
  fifo_stat_t          fstat;
  logic [CODE_W-1:0]   fifo_rdata;

  logic                in_fire;

  kdaq_alu u_alu (
    .op      (alu_op),
    .a       (alu_a),
    .b       (alu_b),
    .thr     (alu_thr),
    .res     (alu_res),
    .reached (alu_reached)
  );

  kdaq_fifo #(.FIFO_DEPTH(FIFO_DEPTH)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (fctrl),
    .stat  (fstat),
    .rdata (fifo_rdata)
  );

  // only the keys that have a pin can read pressed
  for (genvar i = 0; i < NUM_KEYS; i++) begin : g_press
    if (i < LEVEL_W) begin : g_pin
      assign press_vec[i] = ~levels_r[i];
    end else begin : g_nopin
      assign press_vec[i] = 1'b0;
    end
  end

  for (genvar i = 0; i < LEVEL_W; i++) begin : g_held
    if (i < NUM_KEYS) begin : g_key
      assign held_out[i] = held_r[i];
    end else begin : g_nokey
      assign held_out[i] = 1'b0;
    end
  end

  assign pressed   = press_vec[key_r];
  assign held_cur  = held_r[key_r];
  assign key_plus1 = {1'b0, key_r} + (KEY_W+1)'(1);

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    alu_op  = ALU_SUB;
    alu_a   = now_r;
    alu_b   = pressed ? base_r[key_r] : low_r[key_r];
    alu_thr = pressed ? repeat_r : release_r;
    if (state_r == S_EVAL && pressed && !held_cur) begin
      alu_op = ALU_ADD;
      alu_b  = {1'b0, first_r};
    end else if (state_r == S_UPD) begin
      alu_a = acc_r;
      alu_b = {1'b0, repeat_r};
    end
  end

  always_comb begin
    state_nxt     = state_r;
    enable_nxt    = enable_r;
    first_nxt     = first_r;
    repeat_nxt    = repeat_r;
    release_nxt   = release_r;
    held_nxt      = held_r;
    key_nxt       = key_r;
    acc_nxt       = acc_r;
    reach_nxt     = reach_r;
    code_nxt      = code_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    base_we       = 1'b0;
    low_we        = 1'b0;
    base_wdata    = now_r;
    fctrl         = '0;
    fctrl.push_code = key_plus1[CODE_W-1:0];

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ENABLE:       enable_nxt  = cfg_data[0];
        REG_FIRST_REPEAT: first_nxt   = cfg_data;
        REG_REPEAT:       repeat_nxt  = cfg_data;
        REG_RELEASE:      release_nxt = cfg_data;
        default:          enable_nxt  = enable_r;
      endcase
    end

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          key_nxt  = '0;
          code_nxt = '0;
          if (in_tuser) state_nxt = S_POP_RD;
          else if (enable_r) state_nxt = S_EVAL;
          else state_nxt = S_DONE;
        end
      end
      S_EVAL: begin
        acc_nxt   = alu_res;
        reach_nxt = alu_reached;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (pressed) begin
          low_we = 1'b1;
          if (!held_cur) begin
            base_we           = 1'b1;
            base_wdata        = alu_res;
            held_nxt[key_r]   = 1'b1;
            fctrl.push        = 1'b1;
          end else if (reach_r) begin
            base_we    = 1'b1;
            fctrl.push = 1'b1;
          end
        end else if (held_cur && reach_r) begin
          held_nxt[key_r] = 1'b0;
        end
        if (key_r == KEY_LAST) begin
          state_nxt = S_DONE;
        end else begin
          key_nxt   = key_r + KEY_W'(1);
          state_nxt = S_EVAL;
        end
      end
      S_POP_RD: begin
        fctrl.rd  = 1'b1;
        state_nxt = S_POP_TAKE;
      end
      S_POP_TAKE: begin
        fctrl.pop = 1'b1;
        if (!fstat.empty) code_nxt = fifo_rdata;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00, (held_out == '0), held_out, code_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      enable_r    <= 1'b0;
      first_r     <= FIRST_REPEAT_RST;
      repeat_r    <= REPEAT_RST;
      release_r   <= RELEASE_RST;
      held_r      <= '0;
      key_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      enable_r    <= enable_nxt;
      first_r     <= first_nxt;
      repeat_r    <= repeat_nxt;
      release_r   <= release_nxt;
      held_r      <= held_nxt;
      key_r       <= key_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_fire) begin
      levels_r <= in_tdata[LEVEL_W-1:0];
      now_r    <= in_tdata[LEVEL_W+TIME_W-1:LEVEL_W];
    end
    acc_r      <= acc_nxt;
    reach_r    <= reach_nxt;
    code_r     <= code_nxt;
    out_data_r <= out_data_nxt;
    if (base_we) base_r[key_r] <= base_wdata;
    if (low_we) low_r[key_r] <= now_r;
  end

endmodule

FILE: rtl/core/kdaq_alu.sv
// Shared 32-bit add/subtract unit with wrapping signed threshold compare.
`timescale 1ns / 1ps
module kdaq_alu (
  input  kdaq_pkg::alu_op_t                 op,
  input  logic [kdaq_pkg::TIME_W-1:0]       a,
  input  logic [kdaq_pkg::TIME_W-1:0]       b,
  input  logic [kdaq_pkg::TICK_W-1:0]       thr,
  output logic [kdaq_pkg::TIME_W-1:0]       res,
  output logic                              reached
);
  import kdaq_pkg::*;

  always_comb begin
    unique case (op)
      ALU_ADD: res = a + b;
      ALU_SUB: res = a - b;
      default: res = a - b;
    endcase
  end

  // difference must be non-negative as signed and at least the threshold
  assign reached = !res[TIME_W-1] && (res[TICK_W-1:0] >= thr);

endmodule

FILE: rtl/core/kdaq_fifo.sv
// Ring FIFO of key codes, one slot kept free, registered read port.
`timescale 1ns / 1ps
module kdaq_fifo #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  kdaq_pkg::fifo_ctrl_t           ctrl,
  output kdaq_pkg::fifo_stat_t           stat,
  output logic [kdaq_pkg::CODE_W-1:0]    rdata
);
  import kdaq_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 2) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  logic [CODE_W-1:0] mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  wptr_r, wptr_nxt;
  logic [PTR_W-1:0]  rptr_r, rptr_nxt;
  logic [PTR_W-1:0]  wnext, rnext;
  logic [CODE_W-1:0] rdata_r;
  logic              full, empty;

  assign wnext = (wptr_r == PTR_LAST) ? '0 : wptr_r + PTR_W'(1);
  assign rnext = (rptr_r == PTR_LAST) ? '0 : rptr_r + PTR_W'(1);
  assign full  = (wnext == rptr_r);
  assign empty = (rptr_r == wptr_r);

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    if (ctrl.push && !full) wptr_nxt = wnext;
    if (ctrl.pop && !empty) rptr_nxt = rnext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push && !full) mem[wptr_r] <= ctrl.push_code;
    if (ctrl.rd) rdata_r <= mem[rptr_r];
  end

  assign stat.empty = empty;
  assign rdata      = rdata_r;

endmodule
